// ----- rtl/core/udr_pkg.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator package
// Shared widths, reset values, register indexes and interface structs.
// -----------------------------------------------------------------------------
package udr_pkg;

   localparam int SIDE_W    = 13;
   localparam int DIV_CNT_W = $clog2(SIDE_W + 1);
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int PROD_W    = 20;
   localparam int ADDR_W    = 4;
   localparam int CSR_W     = 32;

   localparam logic [SIDE_W-1:0]    CNT_MAX   = {SIDE_W{1'b1}};
   localparam logic [SIDE_W-1:0]    ONE       = SIDE_W'(1);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(SIDE_W);

   localparam logic [SIDE_W-1:0] RST_SRC_W = SIDE_W'(640);
   localparam logic [SIDE_W-1:0] RST_SRC_H = SIDE_W'(480);
   localparam logic [SIDE_W-1:0] RST_DST_W = SIDE_W'(240);
   localparam logic [SIDE_W-1:0] RST_DST_H = SIDE_W'(180);

   typedef enum logic [1:0] {
      REG_SRC_W = 2'd0,
      REG_SRC_H = 2'd1,
      REG_DST_W = 2'd2,
      REG_DST_H = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic              busy;
      logic [SIDE_W-1:0] quot;
   } div_res_type;

   typedef struct packed {
      logic [7:0] cb;
      logic [7:0] cr;
      logic [7:0] y_even;
      logic [7:0] y_odd;
      logic       keep_even;
      logic       keep_odd;
      logic       row_end_even;
      logic       frame_end_even;
      logic       row_end_odd;
      logic       frame_end_odd;
   } blk_type;

   function automatic logic [SIDE_W-1:0] sat_add(input logic [SIDE_W-1:0] a,
                                                 input logic [SIDE_W-1:0] b);
      logic [SIDE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SIDE_W] ? CNT_MAX : s[SIDE_W-1:0];
   endfunction

endpackage

// ----- rtl/core/udr_div.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator ratio divider
// Restoring divider, one quotient bit per cycle; a zero result reads as one.
// -----------------------------------------------------------------------------
module udr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [udr_pkg::SIDE_W-1:0] dividend,
   input  logic [udr_pkg::SIDE_W-1:0] divisor,
   output udr_pkg::div_res_type       res
);

   logic                          busy_ff, busy_in;
   logic [udr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [udr_pkg::SIDE_W-1:0]    rem_ff, rem_in;
   logic [udr_pkg::SIDE_W-1:0]    quo_ff, quo_in;
   logic [udr_pkg::SIDE_W-1:0]    dvs_ff, dvs_in;
   logic [udr_pkg::SIDE_W:0]      shifted;
   logic [udr_pkg::SIDE_W+1:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[udr_pkg::SIDE_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = udr_pkg::DIV_STEPS;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == udr_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
         if (!diff[udr_pkg::SIDE_W+1]) begin
            rem_in = diff[udr_pkg::SIDE_W-1:0];
            quo_in = {quo_ff[udr_pkg::SIDE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[udr_pkg::SIDE_W-1:0];
            quo_in = {quo_ff[udr_pkg::SIDE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign res.busy = busy_ff;
   assign res.quot = ((dvs_ff == '0) || (quo_ff == '0)) ? udr_pkg::ONE : quo_ff;

endmodule

// ----- rtl/core/udr_front.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator front end
// Tracks source and destination positions and marks the kept pixels of a block.
// -----------------------------------------------------------------------------
module udr_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,
   input  logic                       req_tuser,
   input  logic [udr_pkg::SIDE_W-1:0] src_width,
   input  logic [udr_pkg::SIDE_W-1:0] src_height,
   input  logic [udr_pkg::SIDE_W-1:0] dst_width,
   input  logic [udr_pkg::SIDE_W-1:0] dst_height,
   input  logic [udr_pkg::SIDE_W-1:0] col_quot,
   input  logic [udr_pkg::SIDE_W-1:0] row_quot,
   input  logic                       div_busy,
   input  logic                       q_full,
   output logic                       q_push,
   output udr_pkg::blk_type           q_data
);

   localparam int W = udr_pkg::SIDE_W;

   logic [W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [W-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [W-1:0] col_step_ff, col_step_in, row_step_ff, row_step_in;
   logic [W-1:0] kept_col_ff, kept_col_in, kept_row_ff, kept_row_in;

   logic         accept, sof, row_kept, keep0, keep1, row_done;
   logic [W-1:0] sc, sr, dc, dr, cstep, rstep, nkc, nkr, dc1, nkc1;
   logic [W:0]   col1, sc_next, sr_next, dc_next0, dc_next1, dr_next;

   assign req_tready = !div_busy && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign sof        = req_tuser;

   always_comb begin
      sc    = sof ? '0 : src_col_ff;
      sr    = sof ? '0 : src_row_ff;
      dc    = sof ? '0 : dst_col_ff;
      dr    = sof ? '0 : dst_row_ff;
      nkc   = sof ? '0 : kept_col_ff;
      nkr   = sof ? '0 : kept_row_ff;
      cstep = sof ? col_quot : col_step_ff;
      rstep = sof ? row_quot : row_step_ff;

      row_kept = (sr == nkr) && (dr < dst_height);
      keep0    = row_kept && (sc < src_width) && (sc == nkc) && (dc < dst_width);
      dc_next0 = {1'b0, dc} + 1'b1;
      dc1      = keep0 ? dc_next0[W-1:0] : dc;
      nkc1     = keep0 ? udr_pkg::sat_add(nkc, cstep) : nkc;

      col1     = {1'b0, sc} + 1'b1;
      keep1    = row_kept && (col1 < {1'b0, src_width}) && (col1 == {1'b0, nkc1}) &&
                 (dc1 < dst_width);
      dc_next1 = {1'b0, dc1} + 1'b1;
      dr_next  = {1'b0, dr} + 1'b1;

      sc_next  = {1'b0, sc} + (W+1)'(2);
      sr_next  = {1'b0, sr} + 1'b1;
      row_done = sc_next >= {1'b0, src_width};

      q_data.cb             = req_tdata[7:0];
      q_data.y_even         = req_tdata[15:8];
      q_data.cr             = req_tdata[23:16];
      q_data.y_odd          = req_tdata[31:24];
      q_data.keep_even      = keep0;
      q_data.keep_odd       = keep1;
      q_data.row_end_even   = dc_next0 == {1'b0, dst_width};
      q_data.frame_end_even = (dc_next0 == {1'b0, dst_width}) &&
                              (dr_next == {1'b0, dst_height});
      q_data.row_end_odd    = dc_next1 == {1'b0, dst_width};
      q_data.frame_end_odd  = (dc_next1 == {1'b0, dst_width}) &&
                              (dr_next == {1'b0, dst_height});
      q_push                = accept && (keep0 || keep1);

      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      dst_col_in  = dst_col_ff;
      dst_row_in  = dst_row_ff;
      kept_col_in = kept_col_ff;
      kept_row_in = kept_row_ff;
      col_step_in = col_step_ff;
      row_step_in = row_step_ff;
      if (accept) begin
         col_step_in = cstep;
         row_step_in = rstep;
         if (row_done) begin
            src_col_in  = '0;
            dst_col_in  = '0;
            kept_col_in = '0;
            dst_row_in  = row_kept ? dr_next[W-1:0] : dr;
            kept_row_in = row_kept ? udr_pkg::sat_add(nkr, rstep) : nkr;
            if (sr_next >= {1'b0, src_height}) begin
               src_row_in  = '0;
               dst_row_in  = '0;
               kept_row_in = '0;
            end else begin
               src_row_in = sr_next[W-1:0];
            end
         end else begin
            src_col_in  = sc_next[W-1:0];
            src_row_in  = sr;
            dst_col_in  = keep1 ? dc_next1[W-1:0] : dc1;
            dst_row_in  = dr;
            kept_col_in = keep1 ? udr_pkg::sat_add(nkc1, cstep) : nkc1;
            kept_row_in = nkr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         dst_col_ff  <= '0;
         dst_row_ff  <= '0;
         kept_col_ff <= '0;
         kept_row_ff <= '0;
         col_step_ff <= udr_pkg::ONE;
         row_step_ff <= udr_pkg::ONE;
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         dst_col_ff  <= dst_col_in;
         dst_row_ff  <= dst_row_in;
         kept_col_ff <= kept_col_in;
         kept_row_ff <= kept_row_in;
         col_step_ff <= col_step_in;
         row_step_ff <= row_step_in;
      end
   end

endmodule

// ----- rtl/core/udr_fifo.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator block queue
// Small register queue of classified blocks between front and back end.
// -----------------------------------------------------------------------------
module udr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  udr_pkg::blk_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output udr_pkg::blk_type head
);

   udr_pkg::blk_type              mem_ff [udr_pkg::Q_DEPTH];
   logic [udr_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [udr_pkg::Q_PTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{udr_pkg::Q_PTR_W{1'b0}}, push} -
                  {{udr_pkg::Q_PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = count_ff == (udr_pkg::Q_PTR_W+1)'(udr_pkg::Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/udr_back.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator back end
// Emits the kept pixels of each block and converts them to RGB565 in two stages.
// -----------------------------------------------------------------------------
module udr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  udr_pkg::blk_type q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int P = udr_pkg::PROD_W;

   typedef struct packed {
      logic signed [P-1:0] yc;
      logic signed [P-1:0] rv;
      logic signed [P-1:0] gu;
      logic signed [P-1:0] gv;
      logic signed [P-1:0] bu;
      logic                row_end;
      logic                frame_end;
      logic                run_last;
   } prod_type;

   function automatic logic [7:0] clamp8(input logic signed [P-1:0] v);
      logic signed [P-1:0] sh;
      sh = v >>> 8;
      if (v < 0) begin
         return 8'd0;
      end else if (sh > P'(255)) begin
         return 8'hFF;
      end else begin
         return sh[7:0];
      end
   endfunction

   logic                phase_ff, phase_in, s1_valid_ff, s1_valid_in, out_valid_ff, out_valid_in;
   prod_type            s1_ff, s1_in;
   logic [15:0]         pix_ff, pix_in;
   logic [1:0]          user_ff, user_in;
   logic                last_ff, last_in;
   logic                en, take, odd_sel, last_pix;
   logic [7:0]          y;
   logic signed [9:0]   c, d, e;
   logic signed [P-1:0] r_sum, g_sum, b_sum;
   logic [7:0]          r, g, b;

   assign en       = !out_valid_ff || rsp_tready;
   assign take     = en && q_valid;
   assign odd_sel  = phase_ff || !q_head.keep_even;
   assign last_pix = !(q_head.keep_even && q_head.keep_odd && !phase_ff);
   assign q_pop    = take && last_pix;

   always_comb begin
      y = odd_sel ? q_head.y_odd : q_head.y_even;
      c = $signed({2'b00, y}) - 10'sd16;
      d = $signed({2'b00, q_head.cb}) - 10'sd128;
      e = $signed({2'b00, q_head.cr}) - 10'sd128;
      s1_in.yc        = P'(c) * P'(298);
      s1_in.rv        = P'(e) * P'(409);
      s1_in.gu        = P'(d) * P'(100);
      s1_in.gv        = P'(e) * P'(208);
      s1_in.bu        = P'(d) * P'(516);
      s1_in.row_end   = odd_sel ? q_head.row_end_odd : q_head.row_end_even;
      s1_in.frame_end = odd_sel ? q_head.frame_end_odd : q_head.frame_end_even;
      s1_in.run_last  = last_pix;
      phase_in        = take ? !last_pix : phase_ff;
      s1_valid_in     = en ? take : s1_valid_ff;

      r_sum = s1_ff.yc + s1_ff.rv + P'(128);
      g_sum = s1_ff.yc - s1_ff.gu - s1_ff.gv + P'(128);
      b_sum = s1_ff.yc + s1_ff.bu + P'(128);
      r     = clamp8(r_sum);
      g     = clamp8(g_sum);
      b     = clamp8(b_sum);
      pix_in       = {r[7:3], g[7:2], b[7:3]};
      user_in      = {s1_ff.frame_end, s1_ff.row_end};
      last_in      = s1_ff.run_last;
      out_valid_in = en ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (en) begin
         s1_ff   <= s1_in;
         pix_ff  <= pix_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pix_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- rtl/core/uyvy_decimate_to_rgb565_core.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator to RGB565
// Keeps every column_step-th pixel of every row_step-th line of a UYVY stream
// and converts each kept pixel to RGB565 with BT.601 integer coefficients.
// -----------------------------------------------------------------------------
// The req channel takes one UYVY block per word in raster order; tuser marks
// the first block of a frame, which clears the position counters and loads
// the column and row steps. The rsp channel gives zero, one or two RGB565
// pixels per block, even pixel first; tlast marks the last pixel of a block.
// A block with two kept pixels holds the conversion stage while its pixels are
// converted one after the other, so the sustained rate is one block per cycle
// when at most one pixel of each is kept and rsp is not stalled.
// The first pixel of a block reaches rsp through the queue, the product
// register and the output register. A four-block queue sits between the
// position tracker and the converter, so the input keeps flowing while the
// output is stalled until the queue fills.
// After reset and after every register write, the size ratios are computed by
// two bit-serial dividers; req_tready stays low meanwhile.
// Reset restores the default frame sizes and sets both steps to one.
// -----------------------------------------------------------------------------
module uyvy_decimate_to_rgb565_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // cb, luma_even, cr, luma_odd
   input  logic                       req_tuser,   // start_of_frame
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // rgb_pixel
   output logic [1:0]                 rsp_tuser,   // row_end, frame_end
   output logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [udr_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [udr_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [udr_pkg::CSR_W-1:0]  csr_prdata,
   output logic                       csr_pready
);

   localparam int W = udr_pkg::SIDE_W;

   logic [W-1:0]         src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [W-1:0]         dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic                 kick_ff, kick_in, wr_en, div_busy;
   logic [W-1:0]         rd_val;
   udr_pkg::reg_idx_type reg_idx;
   udr_pkg::div_res_type col_res, row_res;
   udr_pkg::blk_type     push_data, head;
   logic                 push, pop, q_full, q_valid;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = udr_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign kick_in    = wr_en;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      rd_val   = src_w_ff;
      unique case (reg_idx)
         udr_pkg::REG_SRC_W: begin
            rd_val = src_w_ff;
            if (wr_en) src_w_in = csr_pwdata[W-1:0];
         end
         udr_pkg::REG_SRC_H: begin
            rd_val = src_h_ff;
            if (wr_en) src_h_in = csr_pwdata[W-1:0];
         end
         udr_pkg::REG_DST_W: begin
            rd_val = dst_w_ff;
            if (wr_en) dst_w_in = csr_pwdata[W-1:0];
         end
         udr_pkg::REG_DST_H: begin
            rd_val = dst_h_ff;
            if (wr_en) dst_h_in = csr_pwdata[W-1:0];
         end
         default: rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(udr_pkg::CSR_W-W){1'b0}}, rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= udr_pkg::RST_SRC_W;
         src_h_ff <= udr_pkg::RST_SRC_H;
         dst_w_ff <= udr_pkg::RST_DST_W;
         dst_h_ff <= udr_pkg::RST_DST_H;
         kick_ff  <= 1'b1;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
         kick_ff  <= kick_in;
      end
   end

   udr_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (kick_ff),
      .dividend (src_w_ff),
      .divisor  (dst_w_ff),
      .res      (col_res)
   );

   udr_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (kick_ff),
      .dividend (src_h_ff),
      .divisor  (dst_h_ff),
      .res      (row_res)
   );

   assign div_busy = kick_ff || col_res.busy || row_res.busy;

   udr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .src_width  (src_w_ff),
      .src_height (src_h_ff),
      .dst_width  (dst_w_ff),
      .dst_height (dst_h_ff),
      .col_quot   (col_res.quot),
      .row_quot   (row_res.quot),
      .div_busy   (div_busy),
      .q_full     (q_full),
      .q_push     (push),
      .q_data     (push_data)
   );

   udr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head)
   );

   udr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/udr_checker.sv -----
// -----------------------------------------------------------------------------
// UYVY decimator port checker
// Port-level properties of the decimator, attached to the top level by bind.
// -----------------------------------------------------------------------------
module udr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic        csr_pready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("Outputs active right after reset.");

   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready) |=> !req_tready)
      else $error("Input accepted while the step ratios are recomputed.");

   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("Frame end without row end.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled pixel changed or dropped.");

endmodule

bind uyvy_decimate_to_rgb565_core udr_checker u_udr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_pready  (csr_pready)
);

// ----- dv/tb_uyvy_decimate_to_rgb565_core.sv -----
// -----------------------------------------------------------------------------
// Testbench for the UYVY decimator to RGB565
// Streams UYVY blocks through the core under several frame size settings and
// compares every RGB565 pixel, with its row, frame and block end flags,
// against a predictor of the position tracking and the BT.601 conversion.
// -----------------------------------------------------------------------------
module tb_uyvy_decimate_to_rgb565_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_CYCLES  = 300;
   localparam int SIZE_MASK     = 8191;
   localparam int SAT_LIMIT     = 8191;

   typedef struct packed {
      logic [15:0] rgb;
      logic        row_end;
      logic        frame_end;
      logic        run_last;
   } rgb_pixel_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata   = '0;
   logic                         req_tuser   = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [15:0]                  rsp_tdata;
   logic [1:0]                   rsp_tuser;
   logic                         rsp_tlast;
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [udr_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [udr_pkg::CSR_W-1:0]    csr_pwdata  = '0;
   logic [udr_pkg::CSR_W-1:0]    csr_prdata;
   logic                         csr_pready;

   rgb_pixel_type pixel_expect_q[$];
   int            csr_size[4];
   int            src_col, src_row, dst_col, dst_row;
   int            col_step, row_step, want_col, want_row;

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_left       = 0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int blocks_accepted = 0;
   int pixels_checked  = 0;
   int settings_used   = 0;

   uyvy_decimate_to_rgb565_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] uyvy(input logic [7:0] cb, input logic [7:0] y_even,
                                        input logic [7:0] cr, input logic [7:0] y_odd);
      return {y_odd, cr, y_even, cb};
   endfunction

   function automatic logic [7:0] clamp_u8(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   function automatic logic [15:0] bt601_to_rgb565(input logic [7:0] y, input logic [7:0] cb,
                                                   input logic [7:0] cr);
      int c, d, e;
      logic [7:0] r, g, b;
      c = int'(y) - 16;
      d = int'(cb) - 128;
      e = int'(cr) - 128;
      r = clamp_u8((298 * c + 409 * e + 128) >>> 8);
      g = clamp_u8((298 * c - 100 * d - 208 * e + 128) >>> 8);
      b = clamp_u8((298 * c + 516 * d + 128) >>> 8);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic int size_ratio(input int src, input int dst);
      int q;
      q = (dst == 0) ? 1 : src / dst;
      return (q == 0) ? 1 : q;
   endfunction

   function automatic int bump_position(input int a, input int b);
      return (a + b > SAT_LIMIT) ? SAT_LIMIT : a + b;
   endfunction

   function automatic void clear_position();
      src_col  = 0;
      src_row  = 0;
      dst_col  = 0;
      dst_row  = 0;
      want_col = 0;
      want_row = 0;
   endfunction

   function automatic void reset_predictor();
      csr_size[udr_pkg::REG_SRC_W] = int'(udr_pkg::RST_SRC_W);
      csr_size[udr_pkg::REG_SRC_H] = int'(udr_pkg::RST_SRC_H);
      csr_size[udr_pkg::REG_DST_W] = int'(udr_pkg::RST_DST_W);
      csr_size[udr_pkg::REG_DST_H] = int'(udr_pkg::RST_DST_H);
      clear_position();
      col_step = 1;
      row_step = 1;
   endfunction

   function automatic void predict_block(input logic sof, input logic [31:0] data);
      logic [7:0] cb, cr;
      logic [7:0] luma[2];
      rgb_pixel_type kept[2];
      logic row_hit;
      int n, k, col;
      cb      = data[7:0];
      luma[0] = data[15:8];
      cr      = data[23:16];
      luma[1] = data[31:24];
      n = 0;
      if (sof) begin
         clear_position();
         col_step = size_ratio(csr_size[udr_pkg::REG_SRC_W], csr_size[udr_pkg::REG_DST_W]);
         row_step = size_ratio(csr_size[udr_pkg::REG_SRC_H], csr_size[udr_pkg::REG_DST_H]);
      end
      row_hit = (src_row == want_row) && (dst_row < csr_size[udr_pkg::REG_DST_H]);
      for (k = 0; k < 2; k++) begin
         col = src_col + k;
         if (row_hit && col < csr_size[udr_pkg::REG_SRC_W] && col == want_col &&
             dst_col < csr_size[udr_pkg::REG_DST_W]) begin
            kept[n].rgb       = bt601_to_rgb565(luma[k], cb, cr);
            kept[n].row_end   = (dst_col + 1 == csr_size[udr_pkg::REG_DST_W]);
            kept[n].frame_end = kept[n].row_end &&
                                (dst_row + 1 == csr_size[udr_pkg::REG_DST_H]);
            kept[n].run_last  = 1'b0;
            dst_col++;
            want_col = bump_position(want_col, col_step);
            n++;
         end
      end
      for (k = 0; k < n; k++) begin
         kept[k].run_last = (k == n - 1);
         pixel_expect_q.push_back(kept[k]);
      end
      if (src_col + 2 >= csr_size[udr_pkg::REG_SRC_W]) begin
         src_col  = 0;
         dst_col  = 0;
         want_col = 0;
         if (row_hit) begin
            dst_row++;
            want_row = bump_position(want_row, row_step);
         end
         if (src_row + 1 >= csr_size[udr_pkg::REG_SRC_H]) begin
            clear_position();
         end else begin
            src_row++;
         end
      end else begin
         src_col += 2;
      end
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_expect_q.size() == 0) begin
            note_mismatch("pixel with none pending", 0, rsp_tdata);
         end else begin
            want = pixel_expect_q.pop_front();
            pixels_checked++;
            if (rsp_tdata !== want.rgb) note_mismatch("rgb565", want.rgb, rsp_tdata);
            if (rsp_tuser[0] !== want.row_end) note_mismatch("row end", want.row_end, rsp_tuser[0]);
            if (rsp_tuser[1] !== want.frame_end) begin
               note_mismatch("frame end", want.frame_end, rsp_tuser[1]);
            end
            if (rsp_tlast !== want.run_last) note_mismatch("block last", want.run_last, rsp_tlast);
         end
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d pixels pending.",
                  cycle_count, pixel_expect_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(input udr_pkg::reg_idx_type idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= udr_pkg::CSR_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_size[idx] = value & SIZE_MASK;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== udr_pkg::CSR_W'(value & SIZE_MASK)) begin
         note_mismatch("register readback", value & SIZE_MASK, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_sizes(input int sw, input int sh, input int dw, input int dh);
      csr_write(udr_pkg::REG_SRC_W, sw);
      csr_write(udr_pkg::REG_SRC_H, sh);
      csr_write(udr_pkg::REG_DST_W, dw);
      csr_write(udr_pkg::REG_DST_H, dh);
      settings_used++;
   endtask

   task automatic send_block(input logic sof, input logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= sof;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_block(sof, data);
      blocks_accepted++;
   endtask

   task automatic wait_for_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixel_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic drain_pixels();
      wait_for_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_block(1'b0, uyvy(8'd0, 8'd0, 8'd0, 8'd255));
      send_block(1'b0, uyvy(8'd255, 8'd255, 8'd255, 8'd0));
      send_block(1'b0, uyvy(8'd128, 8'd16, 8'd128, 8'd235));
      drain_pixels();
   endtask

   task automatic test_extreme_sizes();
      apply_sizes(4096, 4096, 1, 1);
      send_block(1'b1, uyvy(8'd255, 8'd128, 8'd0, 8'd64));
      send_block(1'b0, $urandom());
      send_block(1'b0, $urandom());
      drain_pixels();
      apply_sizes(4096, 4096, 4096, 4096);
      send_block(1'b1, uyvy(8'd0, 8'd255, 8'd255, 8'd16));
      send_block(1'b0, $urandom());
      send_block(1'b0, $urandom());
      drain_pixels();
      apply_sizes(2730, 2730, 1365, 1365);
      send_block(1'b1, $urandom());
      send_block(1'b0, $urandom());
      send_block(1'b0, $urandom());
      drain_pixels();
   endtask

   task automatic test_odd_width_and_wrap();
      int i;
      apply_sizes(5, 2, 5, 1);
      send_block(1'b1, $urandom());
      for (i = 0; i < 9; i++) send_block(1'b0, $urandom());
      drain_pixels();
   endtask

   task automatic test_zero_sizes();
      apply_sizes(0, 0, 0, 0);
      send_block(1'b1, $urandom());
      send_block(1'b0, $urandom());
      send_block(1'b0, $urandom());
      drain_pixels();
   endtask

   task automatic test_output_stall();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_sizes(16, 4, 16, 4);
      hold_left <= STALL_CYCLES;
      for (i = 0; i < 24; i++) send_block(i == 0, $urandom());
      wait_for_pixels();
      for (i = 0; i < 8; i++) send_block(1'b0, $urandom());
      drain_pixels();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_blocks);
      int left, sw, sh, dw, dh, budget, frame_len, i;
      logic sof;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      left = n_blocks;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            sw = $urandom_range(4096, 2);
            sh = $urandom_range(4096, 1);
         end else begin
            sw = $urandom_range(24, 2);
            sh = $urandom_range(8, 1);
         end
         dw = $urandom_range(sw, 1);
         dh = $urandom_range(sh, 1);
         apply_sizes(sw, sh, dw, dh);
         budget = $urandom_range(90, 30);
         if (budget > left) budget = left;
         frame_len = ((sw + 1) / 2) * sh;
         for (i = 0; i < budget; i++) begin
            sof = (i % frame_len == 0);
            if ($urandom_range(99) < 5) sof = !sof;
            send_block(sof, $urandom());
         end
         drain_pixels();
         left -= budget;
      end
   endtask

   initial begin
      reset_predictor();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_sizes();
      test_odd_width_and_wrap();
      test_zero_sizes();
      test_output_stall();
      test_random_traffic(6, 69, 370);
      test_random_traffic(69, 6, 370);
      test_random_traffic(0, 0, 370);
      $display("Sent %0d blocks and checked %0d pixels over %0d size settings.",
               blocks_accepted, pixels_checked, settings_used);
      $display("Covered size extremes, zero sizes, odd widths, frame wrap and output stalls.");
      if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
